[rtl/core/uice_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uice_pkg
// Shared widths, op and status codes and helpers for the integer code encoder.
// ----------------------------------------------------------------------------
package uice_pkg;

    localparam int DEF_VALUE_BITS       = 32;
    localparam int DEF_COUNT_FIELD_BITS = 4;

    localparam int OP_W   = 2;
    localparam int IN_W   = 32;
    localparam int CODE_W = 64;
    localparam int LEN_W  = 6;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_FIXVAR = 2'd0;
    localparam logic [OP_W-1:0] OP_GAMMA  = 2'd1;
    localparam logic [OP_W-1:0] OP_OMEGA  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_ZERO = 2'd1;
    localparam logic [ST_W-1:0] ST_OVF  = 2'd2;

    // significant bits of a 4-bit digit, 0..4
    function automatic logic [2:0] sig_bits4(input logic [3:0] d);
        logic [2:0] n;
        if (d[3]) begin
            n = 3'd4;
        end else if (d[2]) begin
            n = 3'd3;
        end else if (d[1]) begin
            n = 3'd2;
        end else if (d[0]) begin
            n = 3'd1;
        end else begin
            n = 3'd0;
        end
        return n;
    endfunction

endpackage

[rtl/core/uice_bitcnt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uice_bitcnt
// Iterative significant-bit counter: shifts the word right one digit per
// cycle until only the low digit is left, then adds that digit's width.
// ----------------------------------------------------------------------------
module uice_bitcnt #(
    parameter int VALUE_BITS = uice_pkg::DEF_VALUE_BITS,
    parameter int CNT_W      = $clog2(VALUE_BITS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [CNT_W-1:0]      o_count
);

    logic [VALUE_BITS-1:0] r_rem;
    logic [VALUE_BITS-1:0] n_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic                  r_busy;
    logic                  n_busy;
    logic                  w_last;

    assign w_last  = (r_rem[VALUE_BITS-1:4] == '0);
    assign o_busy  = r_busy;
    assign o_done  = r_busy && w_last;
    assign o_count = r_cnt + CNT_W'(uice_pkg::sig_bits4(r_rem[3:0]));

    always_comb begin
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_rem  = i_value;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_last) begin
                n_busy = 1'b0;
            end else begin
                n_rem = r_rem >> 4;
                n_cnt = r_cnt + CNT_W'(4);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

endmodule

[rtl/core/universal_integer_code_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// universal_integer_code_encoder
// Fix+var, Elias gamma and Elias omega encoder, one word at a time.
// ----------------------------------------------------------------------------
// Each bit count takes one 4-bit digit per cycle in the shared counter.
// Fix+var and gamma use one count, omega one count per group. Input ready
// only when the sequencer is idle. Synchronous active-low reset empties the
// sequencer and the output register.
module universal_integer_code_encoder #(
    parameter int VALUE_BITS       = uice_pkg::DEF_VALUE_BITS,
    parameter int COUNT_FIELD_BITS = uice_pkg::DEF_COUNT_FIELD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [uice_pkg::OP_W-1:0]    i_op,
    input  logic [uice_pkg::IN_W-1:0]    i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [uice_pkg::CODE_W-1:0]  o_code_bits,
    output logic [uice_pkg::LEN_W-1:0]   o_code_length,
    output logic [uice_pkg::ST_W-1:0]    o_status
);

    localparam int CNT_W   = $clog2(VALUE_BITS + 1);
    localparam int CNT_MAX = (1 << COUNT_FIELD_BITS) - 1;
    localparam int CODE_W  = uice_pkg::CODE_W;
    localparam int LEN_W   = uice_pkg::LEN_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CNT  = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]                r_state, n_state;
    logic [uice_pkg::OP_W-1:0] r_op, n_op;
    logic [VALUE_BITS-1:0]     r_val, n_val;
    logic [VALUE_BITS-1:0]     r_num, n_num;
    logic [CODE_W-1:0]         r_code, n_code;
    logic [LEN_W-1:0]          r_len, n_len;
    logic [uice_pkg::ST_W-1:0] r_st, n_st;

    logic                      r_out_valid, n_out_valid;
    logic [CODE_W-1:0]         r_out_code;
    logic [LEN_W-1:0]          r_out_len;
    logic [uice_pkg::ST_W-1:0] r_out_st;

    logic                      w_in_acc;
    logic                      w_out_free;
    logic                      w_load_out;
    logic                      w_cnt_start;
    logic [VALUE_BITS-1:0]     w_cnt_value;
    logic                      w_cnt_busy;
    logic                      w_cnt_done;
    logic [CNT_W-1:0]          w_cnt;
    logic [CNT_W-1:0]          w_below;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_load_out  = (r_state == S_HOLD) && w_out_free;
    assign w_below     = (w_cnt != '0) ? w_cnt - CNT_W'(1) : '0;

    uice_bitcnt #(
        .VALUE_BITS (VALUE_BITS),
        .CNT_W      (CNT_W)
    ) u_bitcnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cnt_start),
        .i_value (w_cnt_value),
        .o_busy  (w_cnt_busy),
        .o_done  (w_cnt_done),
        .o_count (w_cnt)
    );

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_val       = r_val;
        n_num       = r_num;
        n_code      = r_code;
        n_len       = r_len;
        n_st        = r_st;
        w_cnt_start = 1'b0;
        w_cnt_value = i_value[VALUE_BITS-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_op   = i_op;
                    n_val  = i_value[VALUE_BITS-1:0];
                    n_num  = i_value[VALUE_BITS-1:0];
                    n_code = '0;
                    n_len  = LEN_W'(1);
                    n_st   = uice_pkg::ST_OK;
                    if (i_op == uice_pkg::OP_FIXVAR || i_op == uice_pkg::OP_GAMMA ||
                        i_op == uice_pkg::OP_OMEGA) begin
                        w_cnt_start = 1'b1;
                        n_state     = S_CNT;
                    end else begin
                        // unused selector: empty code, status ok
                        n_len   = '0;
                        n_state = S_HOLD;
                    end
                end
            end
            S_CNT: begin
                if (w_cnt_done) begin
                    n_state = S_HOLD;
                    unique case (r_op)
                        uice_pkg::OP_FIXVAR: begin
                            if (32'(w_cnt) > CNT_MAX) begin
                                n_code = '0;
                                n_len  = '0;
                                n_st   = uice_pkg::ST_OVF;
                            end else begin
                                n_code = (CODE_W'(w_cnt) << w_below) |
                                         (CODE_W'(r_val) &
                                          ((CODE_W'(1) << w_below) - CODE_W'(1)));
                                n_len  = LEN_W'(COUNT_FIELD_BITS) + LEN_W'(w_below);
                            end
                        end
                        uice_pkg::OP_GAMMA: begin
                            if (w_cnt == '0) begin
                                n_len = '0;
                                n_st  = uice_pkg::ST_ZERO;
                            end else begin
                                n_code = CODE_W'(r_val);
                                n_len  = LEN_W'({w_cnt, 1'b0} - (CNT_W + 1)'(1));
                            end
                        end
                        uice_pkg::OP_OMEGA: begin
                            if (w_cnt == '0) begin
                                n_len = '0;
                                n_st  = uice_pkg::ST_ZERO;
                            end else if (w_cnt > CNT_W'(1)) begin
                                // prepend this group, then count n-1
                                n_code      = r_code | (CODE_W'(r_num) << r_len);
                                n_len       = r_len + LEN_W'(w_cnt);
                                n_num       = VALUE_BITS'(w_below);
                                w_cnt_value = VALUE_BITS'(w_below);
                                w_cnt_start = 1'b1;
                                n_state     = S_CNT;
                            end
                            // a value of one: the closing 0 is already counted
                        end
                        default: begin
                            n_code = '0;
                            n_len  = '0;
                        end
                    endcase
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_op   <= n_op;
        r_val  <= n_val;
        r_num  <= n_num;
        r_code <= n_code;
        r_len  <= n_len;
        r_st   <= n_st;
        if (w_load_out) begin
            r_out_code <= r_code;
            r_out_len  <= r_len;
            r_out_st   <= r_st;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_code_bits   = r_out_code;
    assign o_code_length = r_out_len;
    assign o_status      = r_out_st;

`ifndef SYNTH
    // counter runs only under the sequencer's count state
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CNT) |-> !w_cnt_busy)
        else $error("bit counter busy outside count state");

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CNT) |-> w_cnt_busy)
        else $error("count state without a running count");

    a_accept_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("word accepted but sequencer stayed idle");

    a_empty_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != uice_pkg::ST_OK) |->
        (o_code_length == '0 && o_code_bits == '0))
        else $error("error status with a nonempty code");
`endif

endmodule
